FILE: rtl/rrf_pkg.sv
`timescale 1ns / 1ps
// rrf_pkg: operation codes and payload structs of the receive ring fifo
// no dependencies

package rrf_pkg;

  localparam int unsigned LevelW = 6;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_FLUSH = 2'd2
  } rrf_func_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } rrf_in_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              read_valid;
    logic              dropped;
    logic [LevelW-1:0] level;
  } rrf_out_t;

  // per-item status from the pointer control to the result stage
  typedef struct packed {
    logic              pop_hit;
    logic              dropped;
    logic [LevelW-1:0] level;
  } rrf_status_t;

endpackage

FILE: rtl/rx_ring_fifo_overwrite_oldest_unit.sv
`timescale 1ns / 1ps
// an accepted transfer passes through the read stage and then the output register
// throughput: one item per cycle unless stalled; the byte store read is pipelined behind
// the pointer update, so a pop directly after a push sees the new byte
// stalls only when the output register and the read stage are both held
// reset: pointers and fill count clear to zero, byte store contents undefined
// top level of the receive ring fifo; depends on rrf_pkg, rrf_ctrl, rrf_mem

module rx_ring_fifo_overwrite_oldest_unit #(
  parameter int unsigned DEPTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rrf_pkg::rrf_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rrf_pkg::rrf_out_t out_data_o
);

  import rrf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic          accept;
  logic          advance;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_data;
  rrf_status_t   status;

  logic        pend_q, pend_d;
  rrf_status_t pend_stat_q;
  logic        out_valid_q, out_valid_d;
  rrf_out_t    out_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !pend_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  rrf_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .func_i   (in_data_i.func),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .status_o (status)
  );

  rrf_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(in_data_i.rx_byte),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (advance) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_stat_q <= status;
    end
  end

  // read data is held in the store's output register until this transfer
  always_ff @(posedge clk_i) begin
    if (advance && pend_q) begin
      out_q.read_byte  <= pend_stat_q.pop_hit ? rd_data : 8'd0;
      out_q.read_valid <= pend_stat_q.pop_hit;
      out_q.dropped    <= pend_stat_q.dropped;
      out_q.level      <= pend_stat_q.level;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> pend_q)
    else $error("accepted item not held in read stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && advance) |=> out_valid_q)
    else $error("read stage item lost on its way to output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_o.read_valid) |-> !out_data_o.dropped)
    else $error("pop result flagged as dropped");

endmodule

FILE: rtl/rrf_mem.sv
`timescale 1ns / 1ps
// rrf_mem: byte store, one write port and one registered read port
// no package dependencies

module rrf_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/rrf_ctrl.sv
`timescale 1ns / 1ps
// rrf_ctrl: read/write pointers and fill count, drives the byte store ports
// depends on rrf_pkg

module rrf_ctrl #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          func_i,
  output logic                wr_en_o,
  output logic [AW-1:0]       wr_addr_o,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  output rrf_pkg::rrf_status_t status_o
);

  import rrf_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          full, empty;
  logic [AW-1:0] rd_ptr_nxt, wr_ptr_nxt;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign rd_ptr_nxt = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign wr_ptr_nxt = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;

  always_comb begin
    rd_ptr_d         = rd_ptr_q;
    wr_ptr_d         = wr_ptr_q;
    count_d          = count_q;
    wr_en_o          = 1'b0;
    rd_en_o          = 1'b0;
    status_o.pop_hit = 1'b0;
    status_o.dropped = 1'b0;
    case (func_i)
      FUNC_PUSH: begin
        wr_en_o  = accept_i;
        wr_ptr_d = wr_ptr_nxt;
        if (full) begin
          // overwrite the oldest byte, read side moves along
          rd_ptr_d         = rd_ptr_nxt;
          status_o.dropped = 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      FUNC_POP: begin
        if (!empty) begin
          rd_en_o          = accept_i;
          rd_ptr_d         = rd_ptr_nxt;
          count_d          = count_q - 1'b1;
          status_o.pop_hit = 1'b1;
        end
      end
      FUNC_FLUSH: begin
        rd_ptr_d = '0;
        wr_ptr_d = '0;
        count_d  = '0;
      end
      default: begin
      end
    endcase
    status_o.level = LevelW'(count_d);
  end

  assign wr_addr_o = wr_ptr_q;
  assign rd_addr_o = rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else if (accept_i) begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  // pointers coincide whenever the ring is full or empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CW'(DEPTH) || count_q == '0) |-> rd_ptr_q == wr_ptr_q)
    else $error("pointers disagree with fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && func_i == FUNC_PUSH && full) |=> full)
    else $error("overwrite push lost the full state");

endmodule

FILE: dv/tb_rx_ring_fifo_overwrite_oldest_unit.sv
`timescale 1ns / 1ps
// testbench for the receive ring fifo: drives push, pop, flush and no-op transfers,
// predicts each result from a local ring model and checks it field by field
// depends on rrf_pkg and rx_ring_fifo_overwrite_oldest_unit

module tb_rx_ring_fifo_overwrite_oldest_unit;
  import rrf_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam logic [1:0] FUNC_NOOP = 2'd3;
  localparam int unsigned LongHold = 400;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid;
  logic     in_ready;
  rrf_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  rrf_out_t out_data;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rx_ring_fifo_overwrite_oldest_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // local copy of the ring
  logic [7:0]      ring_mem [DEPTH];
  logic [PtrW-1:0] ring_rd;
  logic [PtrW-1:0] ring_wr;
  int unsigned     ring_fill;

  rrf_out_t ring_results_q[$];
  int unsigned mismatches;
  bit src_idle_en;
  bit sink_idle_en;
  bit stall_request;

  function automatic logic [PtrW-1:0] ring_next(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic rrf_out_t ring_apply(rrf_in_t item);
    rrf_out_t r;
    r = '0;
    case (item.func)
      FUNC_PUSH: begin
        ring_mem[ring_wr] = item.rx_byte;
        ring_wr = ring_next(ring_wr);
        if (ring_fill >= DEPTH) begin
          // full: oldest byte is lost
          ring_rd = ring_next(ring_rd);
          r.dropped = 1'b1;
        end else begin
          ring_fill = ring_fill + 1;
        end
      end
      FUNC_POP: begin
        if (ring_fill != 0) begin
          r.read_byte = ring_mem[ring_rd];
          r.read_valid = 1'b1;
          ring_rd = ring_next(ring_rd);
          ring_fill = ring_fill - 1;
        end
      end
      FUNC_FLUSH: begin
        ring_rd = '0;
        ring_wr = '0;
        ring_fill = 0;
      end
      default: begin
      end
    endcase
    r.level = LevelW'(ring_fill);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  // one input transfer; valid stays high for a following item unless a gap is taken
  task automatic send_item(logic [1:0] func, logic [7:0] rx_byte);
    rrf_in_t item;
    item.func = func;
    item.rx_byte = rx_byte;
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    ring_results_q.push_back(ring_apply(item));
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    rrf_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (ring_results_q.size() == 0) begin
        report_mismatch("unexpected result level", 8'(out_data.level), 8'h00);
      end else begin
        want = ring_results_q.pop_front();
        if (out_data.read_byte !== want.read_byte)
          report_mismatch("read_byte", out_data.read_byte, want.read_byte);
        if (out_data.read_valid !== want.read_valid)
          report_mismatch("read_valid", 8'(out_data.read_valid), 8'(want.read_valid));
        if (out_data.dropped !== want.dropped)
          report_mismatch("dropped", 8'(out_data.dropped), 8'(want.dropped));
        if (out_data.level !== want.level)
          report_mismatch("level", 8'(out_data.level), 8'(want.level));
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold - 1) @(posedge clk_i);
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed_ops();
    send_item(FUNC_POP, 8'h3c);     // pop on empty
    send_item(FUNC_NOOP, 8'hff);    // unused selector on empty
    send_item(FUNC_FLUSH, 8'h00);   // flush on empty
    send_item(FUNC_PUSH, 8'h00);
    send_item(FUNC_PUSH, 8'hff);
    send_item(FUNC_PUSH, 8'ha5);
    send_item(FUNC_POP, 8'h00);
    send_item(FUNC_NOOP, 8'h00);    // no-op with data held
    send_item(FUNC_POP, 8'hff);
    send_item(FUNC_PUSH, 8'h5a);    // push right behind a pop
    send_item(FUNC_POP, 8'h00);
    send_item(FUNC_POP, 8'h00);
    send_item(FUNC_POP, 8'h00);     // empty again
    send_item(FUNC_PUSH, 8'h81);
    send_item(FUNC_PUSH, 8'h7e);
    send_item(FUNC_FLUSH, 8'hff);   // flush with data held
    send_item(FUNC_POP, 8'h00);
    send_item(FUNC_PUSH, 8'h01);
    send_item(FUNC_POP, 8'h00);
  endtask

  // fill past DEPTH so the oldest bytes get overwritten, then drain past empty
  task automatic test_overwrite_when_full();
    repeat (DEPTH + 8) send_item(FUNC_PUSH, 8'($urandom));
    repeat (DEPTH + 2) send_item(FUNC_POP, 8'($urandom));
  endtask

  task automatic test_random_traffic(int unsigned n, int unsigned push_pct);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_item(FUNC_FLUSH, 8'($urandom));
      else if (r < 6) send_item(FUNC_NOOP, 8'($urandom));
      else if (r < 6 + push_pct) send_item(FUNC_PUSH, 8'($urandom));
      else send_item(FUNC_POP, 8'($urandom));
    end
  endtask

  // receiver holds off while the sender keeps offering, so the pipeline backs up
  task automatic test_back_pressure();
    src_idle_en = 1'b0;
    stall_request = 1'b1;
    test_random_traffic(80, 55);
    src_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    mismatches = 0;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    stall_request = 1'b0;
    ring_rd = '0;
    ring_wr = '0;
    ring_fill = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_overwrite_when_full();
    test_back_pressure();
    test_random_traffic(300, 70);
    src_idle_en = 1'b0;
    test_random_traffic(300, 20);
    src_idle_en = 1'b1;
    sink_idle_en = 1'b0;
    test_random_traffic(300, 47);
    sink_idle_en = 1'b1;
    test_random_traffic(300, 60);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    test_random_traffic(300, 50);

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (ring_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (ring_results_q.size() != 0)
      report_mismatch("results left over", 8'(ring_results_q.size()), 8'h00);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
